FILE: design/prc_pkg.sv
// shared constants, types and the controller command struct for the polygon region classifier
package prc_pkg;

   localparam int MaxVertices  = 16;
   localparam int PolygonCount = 4;
   localparam int CoordWidth   = 32;
   localparam int MinPolyVertices = 3;
   localparam int TableDepth   = PolygonCount * MaxVertices;
   localparam int AddrWidth    = $clog2(TableDepth);
   localparam int SlotWidth    = $clog2(MaxVertices);
   localparam int PolyWidth    = $clog2(PolygonCount);
   localparam int DiffWidth    = CoordWidth + 1;
   localparam int ProdWidth    = 2 * DiffWidth;

   typedef enum logic {
      CMD_LOAD     = 1'b0,
      CMD_CLASSIFY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CLASS_TARGET     = 3'd0,
      CLASS_SECOND     = 3'd1,
      CLASS_BACK_ONE   = 3'd2,
      CLASS_BACK_TWO   = 3'd3,
      CLASS_MIXED      = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      CSR_FIRST  = 2'd0,
      CSR_SECOND = 2'd1,
      CSR_THIRD  = 2'd2,
      CSR_FOURTH = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic                 load_point;   // capture request point
      logic                 write_vertex; // store request vertex
      logic                 read_vertex;  // issue table read
      logic [AddrWidth-1:0] read_addr;
      logic                 edge_first;   // read data is last vertex of polygon, start of edge walk
      logic                 edge_step;    // read data is next vertex, evaluate edge
      logic                 mul_step;     // products registered, finish compare
      logic                 poly_done;    // latch inside bit of current polygon
      logic [PolyWidth-1:0] poly;
      logic                 clear_mask;
   } dp_cmd_type;

endpackage

FILE: design/polygon_region_classifier.sv
// top level of the polygon region classifier
//  channel | ports                      | direction
//  request | req_valid/req_ready, req_* | in
//  result  | rsp_valid/rsp_ready, rsp_* | out
//  config  | csr_write_enable, csr_*    | in
// a load request writes the vertex table when it is accepted; a classify request walks each
// polygon's edges one per cycle from the vertex table read port.
// reset is synchronous; the result is held until taken and no request is
// accepted meanwhile.
module polygon_region_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [1:0]        req_polygon_select,
   input  logic [3:0]        req_vertex_slot,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_region,
   output logic              rsp_is_target,
   output logic [3:0]        rsp_inside_mask,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_write_data
);
   import prc_pkg::*;

   dp_cmd_type cmd;
   logic [AddrWidth-1:0] wr_addr;
   logic [PolygonCount-1:0] mask;

   prc_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_polygon_select,
      .req_vertex_slot, .csr_write_enable, .csr_index, .csr_write_data,
      .cmd, .wr_addr, .mask, .rsp_valid, .rsp_ready, .rsp_region,
      .rsp_is_target, .rsp_inside_mask
   );

   prc_datapath u_dp (
      .clock, .reset, .cmd, .wr_addr, .req_x_value, .req_y_value, .mask,
      .point_x(rsp_point_x), .point_y(rsp_point_y)
   );

endmodule

FILE: design/prc_datapath.sv
// vertex tables, edge crossing arithmetic and membership mask
module prc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  prc_pkg::dp_cmd_type      cmd,
   input  logic [prc_pkg::AddrWidth-1:0] wr_addr,
   input  logic signed [31:0]       req_x_value,
   input  logic signed [31:0]       req_y_value,
   output logic [prc_pkg::PolygonCount-1:0] mask,
   output logic signed [31:0]       point_x,
   output logic signed [31:0]       point_y
);
   import prc_pkg::*;

   logic signed [CoordWidth-1:0] x_mem [TableDepth];
   logic signed [CoordWidth-1:0] y_mem [TableDepth];
   logic signed [CoordWidth-1:0] rd_x_ff, rd_y_ff;
   logic signed [CoordWidth-1:0] prev_x_ff, prev_y_ff;
   logic signed [CoordWidth-1:0] px_ff, py_ff;
   logic [31:0] raw_x_ff, raw_y_ff;
   logic signed [ProdWidth-1:0] lhs_ff, rhs_ff;
   logic straddle_ff, parity_ff;
   logic [PolygonCount-1:0] mask_ff;
   logic signed [CoordWidth-1:0] xi, yi, xj, yj;
   logic signed [DiffWidth-1:0] dx_pt, dy_e, dx_e, dy_pt;
   logic signed [DiffWidth-1:0] ma, mb, mc, md;
   logic straddle;

   // vertex tables, registered read
   always_ff @(posedge clock) begin
      if (cmd.write_vertex) begin
         x_mem[wr_addr] <= req_x_value[CoordWidth-1:0];
         y_mem[wr_addr] <= req_y_value[CoordWidth-1:0];
      end
      if (cmd.read_vertex) begin
         rd_x_ff <= x_mem[cmd.read_addr];
         rd_y_ff <= y_mem[cmd.read_addr];
      end
   end

   // edge from previous vertex j to current vertex i; the walk starts with j at the last vertex
   assign xi = rd_x_ff;
   assign yi = rd_y_ff;
   assign xj = prev_x_ff;
   assign yj = prev_y_ff;
   assign straddle = (yi > py_ff) != (yj > py_ff);
   assign dx_pt = DiffWidth'(px_ff) - DiffWidth'(xi);
   assign dy_e  = DiffWidth'(yj) - DiffWidth'(yi);
   assign dx_e  = DiffWidth'(xj) - DiffWidth'(xi);
   assign dy_pt = DiffWidth'(py_ff) - DiffWidth'(yi);

   // operand order flips with the sign of dy
   always_comb begin
      if (dy_e > 0) begin
         ma = dx_pt; mb = dy_e; mc = dx_e; md = dy_pt;
      end else begin
         ma = dx_e; mb = dy_pt; mc = dx_pt; md = dy_e;
      end
   end

   // point capture, edge products and previous vertex
   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         raw_x_ff <= req_x_value;
         raw_y_ff <= req_y_value;
         px_ff    <= req_x_value[CoordWidth-1:0];
         py_ff    <= req_y_value[CoordWidth-1:0];
      end
      if (cmd.edge_first) begin
         prev_x_ff  <= rd_x_ff;
         prev_y_ff  <= rd_y_ff;
      end
      if (cmd.edge_step) begin
         lhs_ff      <= ma * mb;
         rhs_ff      <= mc * md;
         straddle_ff <= straddle;
         prev_x_ff   <= rd_x_ff;
         prev_y_ff   <= rd_y_ff;
      end
   end

   // parity restarts after each polygon so a skipped polygon reads as outside
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         mask_ff   <= '0;
      end else begin
         if (cmd.clear_mask)
            mask_ff <= '0;
         if (cmd.edge_first || cmd.poly_done)
            parity_ff <= 1'b0;
         else if (cmd.mul_step && straddle_ff && (lhs_ff < rhs_ff))
            parity_ff <= ~parity_ff;
         if (cmd.poly_done)
            mask_ff[cmd.poly] <= parity_ff;
      end
   end

   assign mask    = mask_ff;
   assign point_x = raw_x_ff;
   assign point_y = raw_y_ff;

endmodule

FILE: design/prc_controller.sv
// sequencer: request handshake, edge walk over each polygon, result register
module prc_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [1:0]               req_polygon_select,
   input  logic [3:0]               req_vertex_slot,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [4:0]               csr_write_data,
   output prc_pkg::dp_cmd_type      cmd,
   output logic [prc_pkg::AddrWidth-1:0] wr_addr,
   input  logic [prc_pkg::PolygonCount-1:0] mask,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_region,
   output logic                     rsp_is_target,
   output logic [3:0]               rsp_inside_mask
);
   import prc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_POLY, ST_FIRST, ST_EDGE, ST_LAST, ST_DONE, ST_RESULT
   } state_type;

   localparam int CntWidth = $clog2(MaxVertices + 1);

   state_type state_ff, state_in;
   logic [4:0] count_ff [PolygonCount];
   logic [PolyWidth-1:0] poly_ff, poly_in;
   logic [CntWidth-1:0] idx_ff, idx_in, n_cur;
   logic [4:0] raw_n;
   logic mul_pend_ff, mul_pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   class_type code_ff, code_in;
   logic [3:0] mask_out_ff, mask_out_in;
   logic accept;

   // vertex count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PolygonCount; k++) count_ff[k] <= '0;
      end else if (csr_write_enable) begin
         count_ff[csr_index] <= csr_write_data;
      end
   end

   assign raw_n = count_ff[poly_ff];
   assign n_cur = (raw_n > 5'(MaxVertices)) ? CntWidth'(MaxVertices) : CntWidth'(raw_n);
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign wr_addr = AddrWidth'({req_polygon_select, req_vertex_slot});

   // next state and commands
   always_comb begin
      state_in = state_ff;
      poly_in = poly_ff;
      idx_in = idx_ff;
      mul_pend_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      code_in = code_ff;
      mask_out_in = mask_out_ff;
      cmd = '0;
      cmd.poly = poly_ff;
      cmd.read_addr = AddrWidth'({poly_ff, idx_ff[SlotWidth-1:0]});
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.write_vertex = 1'b1;
               end else begin
                  cmd.load_point = 1'b1;
                  cmd.clear_mask = 1'b1;
                  poly_in = '0;
                  state_in = ST_POLY;
               end
            end
         end
         ST_POLY: begin
            // read last vertex first so the first edge is (n-1, 0)
            if (n_cur < CntWidth'(MinPolyVertices)) begin
               state_in = ST_DONE;
               mul_pend_in = '0;
            end else begin
               cmd.read_vertex = 1'b1;
               cmd.read_addr = AddrWidth'({poly_ff, SlotWidth'(n_cur - 1'b1)});
               idx_in = '0;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.edge_first = 1'b1;
            cmd.read_vertex = 1'b1;
            idx_in = idx_ff + 1'b1;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_step = 1'b1;
            mul_pend_in = 1'b1;
            if (idx_ff == n_cur) begin
               state_in = ST_LAST;
            end else begin
               cmd.read_vertex = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            if (mul_pend_ff) cmd.mul_step = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.poly_done = 1'b1;
            if (poly_ff == PolyWidth'(PolygonCount - 1)) begin
               state_in = ST_RESULT;
            end else begin
               poly_in = poly_ff + 1'b1;
               state_in = ST_POLY;
            end
         end
         ST_RESULT: begin
            unique case (mask)
               4'b0001: code_in = CLASS_TARGET;
               4'b0010: code_in = CLASS_SECOND;
               4'b0100: code_in = CLASS_BACK_ONE;
               4'b1000: code_in = CLASS_BACK_TWO;
               default: code_in = CLASS_MIXED;
            endcase
            mask_out_in = mask;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_EDGE && mul_pend_ff) cmd.mul_step = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         poly_ff <= '0;
         idx_ff <= '0;
         mul_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         code_ff <= CLASS_MIXED;
         mask_out_ff <= '0;
      end else begin
         state_ff <= state_in;
         poly_ff <= poly_in;
         idx_ff <= idx_in;
         mul_pend_ff <= mul_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         code_ff <= code_in;
         mask_out_ff <= mask_out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_region = code_ff;
   assign rsp_is_target = (code_ff == CLASS_TARGET);
   assign rsp_inside_mask = mask_out_ff;

   // no request taken while a result waits
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> !req_ready)
      else $error("request accepted with result pending");
   // a result appears only after the classification pass
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("result without classification");
   // polygon pass ends in ST_DONE, which latches its mask bit, then moves to the next polygon or the result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_POLY || state_ff == ST_RESULT))
      else $error("bad polygon sequencing");

endmodule

FILE: tb/tb_polygon_region_classifier.sv
// self-checking testbench for the polygon region classifier
`timescale 1ns / 1ps

module tb_polygon_region_classifier;
   import prc_pkg::*;

   typedef struct {
      cmd_type           cmd;
      logic [1:0]        sel;
      logic [3:0]        slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } request_type;

   typedef struct {
      class_type         code;
      logic              tgt;
      logic [3:0]        mask;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } class_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = 1'b0;
   logic [1:0]        req_polygon_select = '0;
   logic [3:0]        req_vertex_slot = '0;
   logic signed [31:0] req_x_value = '0;
   logic signed [31:0] req_y_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [2:0]        rsp_region;
   logic              rsp_is_target;
   logic [3:0]        rsp_inside_mask;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [4:0]        csr_write_data = '0;

   polygon_region_classifier u_top (.*);

   // predictor state: vertex tables and vertex counts
   logic signed [31:0] vert_x [TableDepth];
   logic signed [31:0] vert_y [TableDepth];
   int unsigned        vert_count [PolygonCount];

   request_type      pending_requests[$];
   class_result_type expected_classes[$];
   bit            failed = 1'b0;
   logic          req_taken = 1'b0;
   logic          rsp_taken = 1'b0;
   int unsigned   req_gap = 0;
   int unsigned   rsp_stall = 0;
   bit            req_burst = 1'b0;
   bit            rsp_burst = 1'b0;

   // stimulus box for well-formed geometry
   longint box_cx, box_cy, box_w;

   initial forever #10 clock = ~clock;

   initial begin
      #25_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // even-odd ray casting with exact cross-multiplied edge test
   function automatic class_result_type classify_point(logic signed [31:0] px,
                                                       logic signed [31:0] py);
      class_result_type r;
      logic [3:0] m;
      int n, i, j, p;
      bit ins;
      logic signed [127:0] pxw, pyw, xi, yi, xj, yj, dy, lhs, rhs;
      m = '0;
      pxw = px;
      pyw = py;
      for (p = 0; p < PolygonCount; p++) begin
         n = (vert_count[p] > MaxVertices) ? MaxVertices : vert_count[p];
         ins = 1'b0;
         if (n >= MinPolyVertices) begin
            j = n - 1;
            for (i = 0; i < n; i++) begin
               xi = vert_x[p*MaxVertices+i];
               yi = vert_y[p*MaxVertices+i];
               xj = vert_x[p*MaxVertices+j];
               yj = vert_y[p*MaxVertices+j];
               if ((yi > pyw) != (yj > pyw)) begin
                  dy = yj - yi;
                  if (dy > 0) begin
                     lhs = (pxw - xi) * dy;
                     rhs = (xj - xi) * (pyw - yi);
                  end else begin
                     lhs = (xj - xi) * (pyw - yi);
                     rhs = (pxw - xi) * dy;
                  end
                  if (lhs < rhs) ins = !ins;
               end
               j = i;
            end
         end
         m[p] = ins;
      end
      case (m)
         4'b0001: r.code = CLASS_TARGET;
         4'b0010: r.code = CLASS_SECOND;
         4'b0100: r.code = CLASS_BACK_ONE;
         4'b1000: r.code = CLASS_BACK_TWO;
         default: r.code = CLASS_MIXED;
      endcase
      r.tgt = (r.code == CLASS_TARGET);
      r.mask = m;
      r.x = px;
      r.y = py;
      return r;
   endfunction

   function automatic int unsigned draw_wait(bit burst);
      if (burst) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic logic signed [31:0] box_coord(longint c);
      longint v;
      v = c + longint'($urandom_range(0, 2 * box_w)) - box_w;
      return v[31:0];
   endfunction

   task automatic push_load(int p, int s, logic signed [31:0] x, logic signed [31:0] y);
      request_type it;
      it.cmd = CMD_LOAD;
      it.sel = 2'(p);
      it.slot = 4'(s);
      it.x = x;
      it.y = y;
      pending_requests.push_back(it);
   endtask

   task automatic push_point(logic signed [31:0] x, logic signed [31:0] y);
      request_type it;
      it.cmd = CMD_CLASSIFY;
      it.sel = 2'($urandom);
      it.slot = 4'($urandom);
      it.x = x;
      it.y = y;
      pending_requests.push_back(it);
   endtask

   // wait for all requests and results to drain, then let the block settle
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_classes.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_counts(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
      int unsigned v [PolygonCount];
      int k;
      v = '{a, b, c, d};
      for (k = 0; k < PolygonCount; k++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= csr_index_type'(k);
         csr_write_data <= 5'(v[k]);
         vert_count[k] = v[k] & 5'h1f;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      request_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            it = pending_requests.pop_front();
            req_cmd <= it.cmd;
            req_polygon_select <= it.sel;
            req_vertex_slot <= it.slot;
            req_x_value <= it.x;
            req_y_value <= it.y;
            req_valid <= 1'b1;
            if ($urandom_range(0, 60) == 0) req_burst = !req_burst;
            req_gap <= draw_wait(req_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall driver
   always @(negedge clock) begin
      int unsigned s;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_ready) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 40) == 0) rsp_burst = !rsp_burst;
            s = draw_wait(rsp_burst);
            if (s != 0) begin
               rsp_ready <= 1'b0;
               rsp_stall <= s - 1;
            end
         end
      end else if (rsp_stall == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_stall <= rsp_stall - 1;
      end
   end

   // monitor: predict on accepted request, check each taken result
   always @(posedge clock) begin
      class_result_type e;
      int idx;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && req_valid && req_ready) begin
         if (req_cmd == CMD_CLASSIFY) begin
            expected_classes.push_back(classify_point(req_x_value, req_y_value));
         end else begin
            idx = req_polygon_select * MaxVertices + req_vertex_slot;
            vert_x[idx] = req_x_value;
            vert_y[idx] = req_y_value;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_classes.size() == 0) begin
            $error("unexpected result, mask %h", rsp_inside_mask);
            failed = 1'b1;
         end else begin
            e = expected_classes.pop_front();
            if (rsp_region !== e.code) begin
               $error("region exp %0d got %0d", e.code, rsp_region);
               failed = 1'b1;
            end
            if (rsp_is_target !== e.tgt) begin
               $error("is_target exp %0d got %0d", e.tgt, rsp_is_target);
               failed = 1'b1;
            end
            if (rsp_inside_mask !== e.mask) begin
               $error("inside_mask exp %b got %b", e.mask, rsp_inside_mask);
               failed = 1'b1;
            end
            if (rsp_point_x !== e.x) begin
               $error("point_x exp %h got %h", e.x, rsp_point_x);
               failed = 1'b1;
            end
            if (rsp_point_y !== e.y) begin
               $error("point_y exp %h got %h", e.y, rsp_point_y);
               failed = 1'b1;
            end
         end
      end
   end

   // stimulus
   initial begin
      int ph, k, r, p, s, idx;
      logic signed [31:0] lo, hi, u;
      lo = 32'sh8000_0000;
      hi = 32'sh7fff_ffff;
      u = 32'sh0001_0000;
      for (k = 0; k < PolygonCount; k++) vert_count[k] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all counts zero: every point is ambiguous
      set_counts(0, 0, 0, 0);
      push_point(lo, lo);
      push_point(hi, hi);
      push_point(0, 0);

      // fill every table entry: two overlapping squares, a rectangle and a full-range triangle
      box_cx = 0;
      box_cy = 0;
      box_w = 1 << 20;
      for (p = 0; p < PolygonCount; p++)
         for (s = 4; s < MaxVertices; s++)
            push_load(p, s, box_coord(0), box_coord(0));
      push_load(0, 0, 0, 0);         push_load(0, 1, 10 * u, 0);
      push_load(0, 2, 10 * u, 10 * u); push_load(0, 3, 0, 10 * u);
      push_load(1, 0, 5 * u, 5 * u);  push_load(1, 1, 15 * u, 5 * u);
      push_load(1, 2, 15 * u, 15 * u); push_load(1, 3, 5 * u, 15 * u);
      push_load(2, 0, -10 * u, -10 * u); push_load(2, 1, 0, -10 * u);
      push_load(2, 2, 0, -u);        push_load(2, 3, -10 * u, -u);
      push_load(3, 0, lo, lo);       push_load(3, 1, hi, lo);
      push_load(3, 2, 0, hi);        push_load(3, 3, lo, hi);
      wait_idle();

      // directed classification over the fixed shapes
      set_counts(4, 4, 4, 3);
      push_point(2 * u, 2 * u);      // target and the big triangle
      push_point(12 * u, 12 * u);    // second and the big triangle
      push_point(7 * u, 7 * u);      // target and second overlap
      push_point(-5 * u, -5 * u);    // background one and the big triangle
      push_point(0, hi);             // apex of the triangle
      push_point(hi, 0);             // outside everything
      push_point(3 * u, 0);          // on a vertex y
      push_point(lo, lo);
      push_point(hi, lo + 1);
      wait_idle();
      // small polygons and counts above the maximum
      set_counts(2, 31, 0, 17);
      push_point(2 * u, 2 * u);
      push_point(-u, -u);
      push_point(0, 0);
      push_point(lo, hi);
      wait_idle();

      // random phases with well-formed geometry and some noise
      for (ph = 0; ph < 14; ph++) begin
         case (ph)
            0: set_counts(16, 16, 16, 16);
            1: set_counts(3, 3, 3, 3);
            2: set_counts(31, 0, 1, 2);
            default: set_counts($urandom_range(0, 4) == 0 ? $urandom_range(0, 31)
                                                           : $urandom_range(3, 16),
                                $urandom_range(0, 31), $urandom_range(2, 16),
                                $urandom_range(3, 20));
         endcase
         box_cx = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
         box_cy = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
         box_w = longint'(1) << $urandom_range(4, 28);
         for (p = 0; p < PolygonCount; p++)
            for (s = 0; s < MaxVertices; s++)
               push_load(p, s, box_coord(box_cx), box_coord(box_cy));
         for (k = 0; k < 66; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               push_load($urandom_range(0, 3), $urandom_range(0, 15),
                         box_coord(box_cx), box_coord(box_cy));
            end else if (r < 75) begin
               push_point(box_coord(box_cx), box_coord(box_cy));
            end else if (r < 85) begin
               idx = $urandom_range(0, TableDepth - 1);
               push_point(box_coord(box_cx), vert_y[idx]);
            end else if (r < 92) begin
               push_load($urandom_range(0, 3), $urandom_range(0, 15), $urandom, $urandom);
            end else begin
               push_point($urandom, $urandom);
            end
         end
         wait_idle();
      end

      if (expected_classes.size() != 0) begin
         $error("%0d results never arrived", expected_classes.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/prc_pkg.sv
design/prc_datapath.sv
design/prc_controller.sv
design/polygon_region_classifier.sv
tb/tb_polygon_region_classifier.sv
